[hw/rtl/gsac_pkg.sv]
`default_nettype none
package gsac_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y  = 3'd6;

  // binding kinds
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_ONE    = 2'd1;
  localparam logic [1:0] KIND_TWO    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0]         RST_KIND      = 2'd2;
  localparam logic [14:0]        RST_DEADZONE  = 15'd5898;
  localparam logic signed [15:0] RST_THRESHOLD = 16'sd16384;
  localparam logic [1:0]         RST_AXIS_EN   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_CHK,
    ST_DIV1,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_FIN
  } state_e;

  // integer square root, used for elaboration-time constants only
  function automatic logic [63:0] isqrt_const(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/gamepad_stick_action_conditioner_top.sv]
// channel   | dir | beat contents (tdata, lowest bit up)
// s_axis    | in  | pos_x_held, neg_x_held, pos_y_held, neg_y_held, pad_connected,
//           |     | stick_x, stick_y, zero fill to whole bytes
// m_axis    | out | value_x, value_y, active, started, canceled, zero fill
// cfg       | in  | write enable, register index, write data (no read-back)
//
// a two-axis item runs SAMPLE_BITS square-root steps and up to three 2*SAMPLE_BITS-step
// divisions on one shared multiplier and one shared restoring divider; a button item
// goes from the idle state straight to the finishing state
// s_axis_tready_o is high only while the sequencer is idle
// a finished result waits in the output register; a stalled m_axis holds the sequencer
// reset clears the configuration to its defaults and the previous-active flag
`default_nettype none
module gamepad_stick_action_conditioner_top #(
  parameter int SAMPLE_BITS = gsac_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // pos_x_held, neg_x_held, pos_y_held, neg_y_held, pad_connected, stick_x, stick_y
  input  wire logic [((2*SAMPLE_BITS+5+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // value_x, value_y, active, started, canceled
  output logic [((2*SAMPLE_BITS+3+7)/8)*8-1:0]  m_axis_tdata_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [gsac_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gsac_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int W      = SAMPLE_BITS;
  localparam int OUT_TW = ((2*W+3+7)/8)*8;
  localparam int CW     = $clog2(2*W);
  localparam int UP     = (W >= 16) ? W - 16 : 0;
  localparam int DN     = (W < 16) ? 16 - W : 0;

  localparam logic [W-1:0]        FULL   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W:0]   MAXV   = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0]   MINV   = -MAXV;
  localparam logic [W-1:0]        DNORM  = W'(gsac_pkg::isqrt_const(64'd1 << (2*W-3)));
  localparam logic [W:0]          KRAW   = (W+1)'(gsac_pkg::isqrt_const(64'd1 << (2*W-1)));
  localparam logic [2*W-1:0]      BIT0   = {2'b01, {(2*W-2){1'b0}}};
  localparam logic [CW-1:0]       DIV_N  = CW'(2*W-1);
  localparam logic [CW-1:0]       SQ_N   = CW'(W-1);
  localparam logic signed [W+15:0] THR_BIAS = ({{(W+15){1'b0}}, 1'b1} << DN) - 1;

  // configuration
  logic [1:0]         kind_q;
  logic [14:0]        dzc_q;
  logic signed [15:0] thr_q;
  logic [1:0]         axen_q;
  logic               norm_q, invx_q, invy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= gsac_pkg::RST_KIND;
      dzc_q  <= gsac_pkg::RST_DEADZONE;
      thr_q  <= gsac_pkg::RST_THRESHOLD;
      axen_q <= gsac_pkg::RST_AXIS_EN;
      norm_q <= 1'b1;
      invx_q <= 1'b0;
      invy_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsac_pkg::REG_KIND:      kind_q <= cfg_data_i[1:0];
        gsac_pkg::REG_DEADZONE:  dzc_q  <= cfg_data_i[14:0];
        gsac_pkg::REG_THRESHOLD: thr_q  <= $signed(cfg_data_i);
        gsac_pkg::REG_AXIS_EN:   axen_q <= cfg_data_i[1:0];
        gsac_pkg::REG_NORMALIZE: norm_q <= cfg_data_i[0];
        gsac_pkg::REG_INVERT_X:  invx_q <= cfg_data_i[0];
        gsac_pkg::REG_INVERT_Y:  invy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // deadzone and threshold rescaled to the sample width
  logic [W+13:0]          dz_wide;
  logic [W-1:0]           dz;
  logic signed [W+15:0]   thr_wide, thr_sum, thr_sh;
  logic signed [W-1:0]    thr;

  always_comb begin
    dz_wide  = {{(W-1){1'b0}}, dzc_q} << (W-1);
    dz       = {1'b0, dz_wide[W+13:15]};
    thr_wide = {{W{thr_q[15]}}, thr_q} <<< UP;
    thr_sum  = thr_wide[W+15] ? thr_wide + THR_BIAS : thr_wide;
    thr_sh   = thr_sum >>> DN;
    thr      = thr_sh[W-1:0];
  end

  // input unpack
  logic                px, nx, py, ny, pad;
  logic signed [W-1:0] sx, sy;
  always_comb begin
    px  = s_axis_tdata_i[0];
    nx  = s_axis_tdata_i[1];
    py  = s_axis_tdata_i[2];
    ny  = s_axis_tdata_i[3];
    pad = s_axis_tdata_i[4];
    sx  = pad ? $signed(s_axis_tdata_i[W+4:5]) : '0;
    sy  = pad ? $signed(s_axis_tdata_i[2*W+4:W+5]) : '0;
  end

  gsac_pkg::state_e state_q, state_d;

  logic [W-1:0]        mx_q, my_q, l_q, s_q, den_q;
  logic                sgx_q, sgy_q;
  logic signed [W:0]   kvx_q, kvy_q;
  logic [W:0]          klen_q;
  logic [2*W-1:0]      num_q, n_q, r_q, b_q;
  logic [W-1:0]        rem_q;
  logic [CW-1:0]       cnt_q;
  logic                ovalid_q, prev_q;
  logic [OUT_TW-1:0]   odata_q;

  wire accept  = s_axis_tvalid_i && s_axis_tready_o;
  wire cnt_end = (cnt_q == '0);
  wire out_free = !ovalid_q || m_axis_tready_i;

  // shared multiplier
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;
  always_comb begin
    mul_a = mx_q;
    mul_b = mx_q;
    case (state_q)
      gsac_pkg::ST_SQY:  begin mul_a = my_q; mul_b = my_q; end
      gsac_pkg::ST_MULX: begin mul_a = mx_q; mul_b = s_q;  end
      gsac_pkg::ST_MULY: begin mul_a = my_q; mul_b = s_q;  end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  // shared restoring divider step
  logic [W:0]     rem_sh;
  logic           q_bit;
  logic [W-1:0]   rem_nx;
  logic [2*W-1:0] num_nx;
  logic [W-1:0]   s_clamp;
  always_comb begin
    rem_sh  = {rem_q, num_q[2*W-1]};
    q_bit   = rem_sh >= {1'b0, den_q};
    rem_nx  = q_bit ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
    num_nx  = {num_q[2*W-2:0], q_bit};
    s_clamp = (num_nx > {{W{1'b0}}, FULL}) ? FULL : num_nx[W-1:0];
  end
  wire stick_wins = {1'b0, s_clamp} > klen_q;

  // square-root step
  logic [2*W-1:0] sq_sum;
  logic           sq_ge;
  always_comb begin
    sq_sum = r_q + b_q;
    sq_ge  = n_q >= sq_sum;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsac_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind_q == gsac_pkg::KIND_ONE)      state_d = gsac_pkg::ST_CHK;
          else if (kind_q == gsac_pkg::KIND_TWO) state_d = gsac_pkg::ST_SQX;
          else                                   state_d = gsac_pkg::ST_FIN;
        end
      end
      gsac_pkg::ST_SQX:  state_d = gsac_pkg::ST_SQY;
      gsac_pkg::ST_SQY:  state_d = gsac_pkg::ST_SQRT;
      gsac_pkg::ST_SQRT: if (cnt_end) state_d = gsac_pkg::ST_CHK;
      gsac_pkg::ST_CHK:  state_d = (l_q > dz) ? gsac_pkg::ST_DIV1 : gsac_pkg::ST_FIN;
      gsac_pkg::ST_DIV1: begin
        if (cnt_end) begin
          if (kind_q == gsac_pkg::KIND_TWO && stick_wins) state_d = gsac_pkg::ST_MULX;
          else                                            state_d = gsac_pkg::ST_FIN;
        end
      end
      gsac_pkg::ST_MULX: state_d = gsac_pkg::ST_DIVX;
      gsac_pkg::ST_DIVX: if (cnt_end) state_d = gsac_pkg::ST_MULY;
      gsac_pkg::ST_MULY: state_d = gsac_pkg::ST_DIVY;
      gsac_pkg::ST_DIVY: if (cnt_end) state_d = gsac_pkg::ST_FIN;
      gsac_pkg::ST_FIN:  if (out_free) state_d = gsac_pkg::ST_IDLE;
      default:           state_d = gsac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gsac_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // outputs
  always_comb begin
    s_axis_tready_o = (state_q == gsac_pkg::ST_IDLE);
    m_axis_tvalid_o = ovalid_q;
    m_axis_tdata_o  = odata_q;
  end

  // key vector and stick magnitudes at accept
  logic signed [W:0] key_x, key_y, dkx, dky, fkx, fky;
  logic              ex, ey, held;
  logic [W-1:0]      ax, ay;
  always_comb begin
    ex   = axen_q[0];
    ey   = axen_q[1];
    held = px || nx || py || ny || (ex && (sx >= thr));
    fkx  = (px && !nx) ? $signed({1'b0, FULL}) :
           (nx && !px) ? -$signed({1'b0, FULL}) : '0;
    fky  = (py && !ny) ? $signed({1'b0, FULL}) :
           (ny && !py) ? -$signed({1'b0, FULL}) : '0;
    dkx  = (px && !nx) ? $signed({1'b0, DNORM}) : -$signed({1'b0, DNORM});
    dky  = (py && !ny) ? $signed({1'b0, DNORM}) : -$signed({1'b0, DNORM});
    key_x = fkx;
    key_y = fky;
    if (fkx != '0 && fky != '0 && norm_q) begin
      key_x = dkx;
      key_y = dky;
    end
    ax = (ex && sx[W-1]) ? W'(-sx) : (ex ? W'(sx) : '0);
    ay = (ey && sy[W-1]) ? W'(-sy) : (ey ? W'(sy) : '0);
  end

  // finishing: saturate, invert, flags
  logic signed [W:0]   sat_x, sat_y;
  logic signed [W-1:0] vx, vy;
  logic                act;
  always_comb begin
    sat_x = (kvx_q > MAXV) ? MAXV : ((kvx_q < MINV) ? MINV : kvx_q);
    sat_y = (kvy_q > MAXV) ? MAXV : ((kvy_q < MINV) ? MINV : kvy_q);
    vx    = (invx_q && kind_q != gsac_pkg::KIND_BUTTON) ? -sat_x[W-1:0] : sat_x[W-1:0];
    vy    = invy_q ? -sat_y[W-1:0] : sat_y[W-1:0];
    act   = (vx != '0) || (vy != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      prev_q   <= 1'b0;
    end else begin
      if (state_q == gsac_pkg::ST_FIN && out_free) begin
        ovalid_q <= 1'b1;
        prev_q   <= act;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gsac_pkg::ST_FIN && out_free) begin
      odata_q <= {{(OUT_TW-2*W-3){1'b0}}, !act && prev_q, act && !prev_q, act, vy, vx};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      gsac_pkg::ST_IDLE: begin
        if (accept) begin
          kvy_q <= (kind_q == gsac_pkg::KIND_TWO) ? key_y : '0;
          if (kind_q == gsac_pkg::KIND_BUTTON) begin
            kvx_q <= held ? MAXV : '0;
          end else if (kind_q == gsac_pkg::KIND_ONE) begin
            kvx_q  <= fkx;
            klen_q <= (px ^ nx) ? {1'b0, FULL} : '0;
            l_q    <= ax;
            sgx_q  <= ex && sx[W-1];
          end else if (kind_q == gsac_pkg::KIND_TWO) begin
            kvx_q  <= key_x;
            klen_q <= (fkx != '0 && fky != '0) ? (norm_q ? {1'b0, FULL} : KRAW) :
                      ((fkx != '0 || fky != '0) ? {1'b0, FULL} : '0);
            mx_q   <= ax;
            my_q   <= ay;
            sgx_q  <= ex && sx[W-1];
            sgy_q  <= ey && !sy[W-1] && (sy != '0);
          end else begin
            kvx_q <= '0;
          end
        end
      end
      gsac_pkg::ST_SQX: n_q <= prod;
      gsac_pkg::ST_SQY: begin
        n_q   <= n_q + prod;
        r_q   <= '0;
        b_q   <= BIT0;
        cnt_q <= SQ_N;
      end
      gsac_pkg::ST_SQRT: begin
        if (sq_ge) begin
          n_q <= n_q - sq_sum;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q   <= b_q >> 2;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_end) l_q <= sq_ge ? W'((r_q >> 1) + b_q) : W'(r_q >> 1);
      end
      gsac_pkg::ST_CHK: begin
        num_q <= {1'b0, W'(l_q - dz), {(W-1){1'b0}}};
        den_q <= FULL - dz;
        rem_q <= '0;
        cnt_q <= DIV_N;
      end
      gsac_pkg::ST_DIV1: begin
        num_q <= num_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_end) begin
          s_q <= s_clamp;
          if (kind_q == gsac_pkg::KIND_ONE && stick_wins) begin
            kvx_q <= sgx_q ? -$signed({1'b0, s_clamp}) : $signed({1'b0, s_clamp});
          end
        end
      end
      gsac_pkg::ST_MULX, gsac_pkg::ST_MULY: begin
        num_q <= prod;
        den_q <= l_q;
        rem_q <= '0;
        cnt_q <= DIV_N;
      end
      gsac_pkg::ST_DIVX: begin
        num_q <= num_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_end) begin
          kvx_q <= sgx_q ? -$signed({1'b0, num_nx[W-1:0]}) : $signed({1'b0, num_nx[W-1:0]});
        end
      end
      gsac_pkg::ST_DIVY: begin
        num_q <= num_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_end) begin
          kvy_q <= sgy_q ? -$signed({1'b0, num_nx[W-1:0]}) : $signed({1'b0, num_nx[W-1:0]});
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[verif/gsac_checker.sv]
`timescale 1ns / 1ps
module gsac_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam longint FULL = 64'sd32768;
  localparam longint MAXV = FULL - 1;

  logic [1:0]         kind_q;
  logic [14:0]        dz_q;
  logic signed [15:0] thr_q;
  logic [1:0]         axis_en_q;
  logic               norm_q;
  logic               inv_x_q;
  logic               inv_y_q;
  logic               was_active;
  logic [34:0]        expected_beats[$];

  function automatic longint sqrt_floor(input longint unsigned n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd4294967296;
    // largest r with r*r <= n
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return longint'(lo);
  endfunction

  function automatic longint clip(input longint v);
    if (v > MAXV) return MAXV;
    if (v < -MAXV) return -MAXV;
    return v;
  endfunction

  function automatic longint absval(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // value_x, value_y and active for one beat; started/canceled added by the caller
  function automatic logic [32:0] condition_item(input logic [39:0] d);
    longint px, nx, py, ny, sx, sy, dz, thr, vx, vy;
    longint kv, a, s, kx, ky, kvx, kvy, klen, cx, cy, ln;
    logic   held;
    logic   ex;
    logic   ey;
    px = d[0];
    nx = d[1];
    py = d[2];
    ny = d[3];
    sx = d[4] ? longint'($signed(d[20:5])) : 0;
    sy = d[4] ? longint'($signed(d[36:21])) : 0;
    ex = axis_en_q[0];
    ey = axis_en_q[1];
    dz = longint'(dz_q);
    thr = longint'(thr_q);
    vx = 0;
    vy = 0;
    case (kind_q)
      gsac_pkg::KIND_BUTTON: begin
        held = (d[3:0] != 4'd0) || (ex && sx >= thr);
        vx = held ? MAXV : 0;
      end
      gsac_pkg::KIND_ONE: begin
        kv = (px - nx) * FULL;
        a = ex ? sx : 0;
        if (absval(a) <= dz) begin
          a = 0;
        end else begin
          s = (absval(a) - dz) * FULL / (FULL - dz);
          a = (a < 0) ? -s : s;
        end
        if (absval(a) > absval(kv)) kv = a;
        vx = clip(kv);
        if (inv_x_q) vx = -vx;
      end
      gsac_pkg::KIND_TWO: begin
        kx = px - nx;
        ky = py - ny;
        kvx = kx * FULL;
        kvy = ky * FULL;
        if (kx != 0 && ky != 0) begin
          if (norm_q) begin
            kvx = kx * sqrt_floor(FULL * FULL / 2);
            kvy = ky * sqrt_floor(FULL * FULL / 2);
            klen = FULL;
          end else begin
            klen = sqrt_floor(2 * FULL * FULL);
          end
        end else begin
          klen = (kx != 0 || ky != 0) ? FULL : 0;
        end
        cx = ex ? sx : 0;
        cy = ey ? -sy : 0;
        ln = sqrt_floor(cx * cx + cy * cy);
        if (ln > dz) begin
          s = (ln - dz) * FULL / (FULL - dz);
          if (s > FULL) s = FULL;
          // stick only wins when strictly longer than the key vector
          if (s > klen) begin
            kvx = cx * s / ln;
            kvy = cy * s / ln;
          end
        end
        vx = clip(kvx);
        vy = clip(kvy);
        if (inv_x_q) vx = -vx;
        if (inv_y_q) vy = -vy;
      end
      default: ;
    endcase
    return {(vx != 0 || vy != 0), vy[15:0], vx[15:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [32:0] core;
    logic [34:0] want;
    logic [34:0] got;
    if (!rst_ni) begin
      kind_q     <= gsac_pkg::RST_KIND;
      dz_q       <= gsac_pkg::RST_DEADZONE;
      thr_q      <= gsac_pkg::RST_THRESHOLD;
      axis_en_q  <= gsac_pkg::RST_AXIS_EN;
      norm_q     <= 1'b1;
      inv_x_q    <= 1'b0;
      inv_y_q    <= 1'b0;
      was_active <= 1'b0;
      errors_o   <= 0;
      expected_beats.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gsac_pkg::REG_KIND:      kind_q    <= cfg_data_i[1:0];
          gsac_pkg::REG_DEADZONE:  dz_q      <= cfg_data_i[14:0];
          gsac_pkg::REG_THRESHOLD: thr_q     <= cfg_data_i;
          gsac_pkg::REG_AXIS_EN:   axis_en_q <= cfg_data_i[1:0];
          gsac_pkg::REG_NORMALIZE: norm_q    <= cfg_data_i[0];
          gsac_pkg::REG_INVERT_X:  inv_x_q   <= cfg_data_i[0];
          gsac_pkg::REG_INVERT_Y:  inv_y_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        core = condition_item(s_axis_tdata_i);
        expected_beats.push_back({was_active && !core[32], core[32] && !was_active, core});
        was_active <= core[32];
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[34:0];
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected output beat %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_beats.pop_front();
          if (got[15:0] !== want[15:0] || got[31:16] !== want[31:16] ||
              got[32] !== want[32] || got[33] !== want[33] || got[34] !== want[34]) begin
            $display({"%0t: mismatch exp x=%0d y=%0d act=%b st=%b cn=%b",
                      " got x=%0d y=%0d act=%b st=%b cn=%b"},
                     $time, $signed(want[15:0]), $signed(want[31:16]), want[32], want[33],
                     want[34], $signed(got[15:0]), $signed(got[31:16]), got[32], got[33],
                     got[34]);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_beats.size();

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int DRAIN_CYCLES = 130;
  localparam int WATCHDOG_MAX = 6000;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gamepad_stick_action_conditioner_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  gsac_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(6500, 5300));
      4: return -16'($urandom_range(6500, 5300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [39:0] make_beat(input logic [3:0] keys, input logic pad,
                                            input logic [15:0] sx, input logic [15:0] sy);
    return {3'b000, sy, sx, pad, keys};
  endfunction

  task automatic send_beat(input logic [39:0] beat);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [1:0] kind, input logic [14:0] dz,
                          input logic [15:0] thr, input logic [1:0] en,
                          input logic norm, input logic ix, input logic iy);
    logic [15:0] vals[7];
    vals = '{16'(kind), 16'(dz), thr, 16'(en), 16'(norm), 16'(ix), 16'(iy)};
    for (int i = 0; i < 7; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0]  kind;
    logic [14:0] dz;
    logic [15:0] thr;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: button with pad absent, threshold edge and key bits
    set_regs(gsac_pkg::KIND_BUTTON, 15'd5898, 16'h4000, 2'd1, 1'b1, 1'b0, 1'b0);
    send_beat(make_beat(4'b0000, 1'b1, 16'h4000, 16'h0000));
    send_beat(make_beat(4'b0000, 1'b1, 16'h3FFF, 16'h7FFF));
    send_beat(make_beat(4'b1000, 1'b0, 16'h7FFF, 16'h0000));
    send_beat(make_beat(4'b0000, 1'b0, 16'h7FFF, 16'h0000));
    drain();
    // one-axis: opposite keys, most negative sample, deadzone edge
    set_regs(gsac_pkg::KIND_ONE, 15'd5898, 16'h4000, 2'd3, 1'b1, 1'b1, 1'b0);
    send_beat(make_beat(4'b0011, 1'b1, 16'h0000, 16'h0000));
    send_beat(make_beat(4'b0000, 1'b1, 16'h8000, 16'h0000));
    send_beat(make_beat(4'b0001, 1'b1, 16'd5898, 16'h0000));
    send_beat(make_beat(4'b0010, 1'b1, 16'd5899, 16'h7FFF));
    drain();
    // two-axis: diagonals, stick corners, pad absent
    set_regs(gsac_pkg::KIND_TWO, 15'd5898, 16'h4000, 2'd3, 1'b1, 1'b0, 1'b1);
    send_beat(make_beat(4'b0101, 1'b1, 16'h0000, 16'h0000));
    send_beat(make_beat(4'b1010, 1'b1, 16'h8000, 16'h8000));
    send_beat(make_beat(4'b0000, 1'b1, 16'h7FFF, 16'h8000));
    send_beat(make_beat(4'b0000, 1'b0, 16'h7FFF, 16'h7FFF));
    send_beat(make_beat(4'b1111, 1'b1, 16'h0100, 16'hFF00));
    drain();
    set_regs(gsac_pkg::KIND_TWO, 15'd0, 16'h8000, 2'd2, 1'b0, 1'b1, 1'b0);
    send_beat(make_beat(4'b1001, 1'b1, 16'h7FFF, 16'h7FFF));
    send_beat(make_beat(4'b0110, 1'b1, 16'h8000, 16'h0001));
    drain();
    // unused binding kind
    set_regs(gsac_pkg::KIND_UNUSED, 15'h7FFF, 16'h7FFF, 2'd0, 1'b0, 1'b1, 1'b1);
    send_beat(make_beat(4'b1111, 1'b1, 16'h7FFF, 16'h8000));
    send_beat(make_beat(4'b0001, 1'b1, 16'h8000, 16'h7FFF));
    drain();

    for (int p = 0; p < 12; p++) begin
      kind = (p < 4) ? 2'(p) : 2'($urandom_range(3));
      case ($urandom_range(3))
        0: dz = 15'd0;
        1: dz = 15'h7FFF;
        2: dz = 15'($urandom_range(8000));
        default: dz = 15'($urandom);
      endcase
      case ($urandom_range(3))
        0: thr = 16'h8000;
        1: thr = 16'h7FFF;
        default: thr = 16'($urandom);
      endcase
      if (p == 1) dz = 15'h7FFF;
      if (p == 2) dz = 15'd0;
      set_regs(kind, dz, thr, 2'($urandom_range(3)), 1'($urandom), 1'($urandom),
               1'($urandom));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (int i = 0; i < 160; i++) begin
        if (i == 40 && (p % 4) != 1) hold_requests = hold_requests + 1;
        if (i == 100) begin
          // sender waits until every result is back
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_beat(make_beat(4'($urandom), ($urandom_range(9) != 0), pick_sample(),
                            pick_sample()));
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
